@@ sv/tba_pkg.sv @@
// shared types and constants of the tile band colour averager
package tba_pkg;

  localparam int unsigned TileW   = 9;
  localparam int unsigned GapW    = 8;
  localparam int unsigned ImgW    = 13;
  localparam int unsigned PosW    = 12;
  localparam int unsigned StrideW = 10;
  localparam int unsigned ColsW   = 7;
  localparam int unsigned SumW    = 24;
  localparam int unsigned CntW    = 17;
  localparam int unsigned IdW     = 19;
  localparam int unsigned AvgW    = 16;
  localparam int unsigned DivNW   = 32;
  localparam int unsigned CfgIdxW = 3;
  localparam int unsigned CfgW    = 13;

  localparam logic [7:0]      AlphaMin = 8'd8;
  localparam logic [ImgW-1:0] MaxImage = 13'd4096;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_TILE_W  = 3'd0,
    CFG_TILE_H  = 3'd1,
    CFG_SPACING = 3'd2,
    CFG_MARGIN  = 3'd3,
    CFG_SAMPLE  = 3'd4,
    CFG_IMG_W   = 3'd5,
    CFG_IMG_H   = 3'd6,
    CFG_NONE    = 3'd7
  } cfg_idx_e;

  // one stored word per tile column
  typedef struct packed {
    logic [SumW-1:0] sum_r;
    logic [SumW-1:0] sum_g;
    logic [SumW-1:0] sum_b;
    logic [CntW-1:0] cnt;
  } col_acc_t;

endpackage

@@ sv/tba_if.sv @@
// pixel and result channel interfaces
interface tba_pix_if import tba_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink (input valid, red, green, blue, alpha, output ready);
endinterface

interface tba_res_if import tba_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [IdW-1:0]  tile_id;
  logic [AvgW-1:0] avg_red;
  logic [AvgW-1:0] avg_green;
  logic [AvgW-1:0] avg_blue;
  logic            last_of_run;
  modport source (output valid, tile_id, avg_red, avg_green, avg_blue, last_of_run,
                  input ready);
  modport sink (input valid, tile_id, avg_red, avg_green, avg_blue, last_of_run,
                output ready);
endinterface

@@ sv/tile_top_band_color_average.sv @@
// Tile band colour averager: RGBA pixels enter in raster order, one per cycle while
// the block runs; per-column sums live in one memory of MAX_COLS words, updated by a
// read-modify-write with forwarding so consecutive pixels of one column do not stall.
// The pixel that ends a tile row's band stops input for a sweep over all MAX_COLS
// entries (each read in S_RD, then checked and cleared in S_CHK); each tile with
// pixels adds a division of all three channels at once and an S_PUSH step to queue
// its item, which waits longer while results are stalled; a frame end without a band
// end costs the same sweep without divisions. After reset the same sweep clears the
// memory, and after reset or any configuration write, tile positions are re-derived
// by up to four divisions before the next item is taken.
module tile_top_band_color_average import tba_pkg::*; #(
  parameter int unsigned MAX_COLS     = 64,
  parameter int unsigned MAX_TILE_DIM = 256
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  tba_pix_if.sink            pix_i,
  tba_res_if.source          res_o
);

  localparam int unsigned AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned KW = $clog2(MAX_COLS + 1);

  typedef enum logic [3:0] {
    S_RUN, S_WAIT, S_RD, S_CHK, S_DIV, S_PUSH, S_FLUSH, S_RCPOS, S_RCSTART, S_RCWAIT
  } state_e;

  // configuration
  logic [TileW-1:0] tile_w_q, tile_h_q, sample_q;
  logic [GapW-1:0]  spacing_q, margin_q;
  logic [ImgW-1:0]  img_w_q, img_h_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tile_w_q  <= 9'd16;
      tile_h_q  <= 9'd16;
      spacing_q <= '0;
      margin_q  <= '0;
      sample_q  <= 9'd1;
      img_w_q   <= 13'd256;
      img_h_q   <= 13'd256;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_TILE_W:  tile_w_q  <= cfg_data_i[TileW-1:0];
        CFG_TILE_H:  tile_h_q  <= cfg_data_i[TileW-1:0];
        CFG_SPACING: spacing_q <= cfg_data_i[GapW-1:0];
        CFG_MARGIN:  margin_q  <= cfg_data_i[GapW-1:0];
        CFG_SAMPLE:  sample_q  <= cfg_data_i[TileW-1:0];
        CFG_IMG_W:   img_w_q   <= cfg_data_i;
        CFG_IMG_H:   img_h_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // effective geometry
  logic [ImgW-1:0]    w, h, m2;
  logic [TileW-1:0]   tw, th, sr0, sr;
  logic [StrideW-1:0] sx, sy;
  logic               geo_ok;

  always_comb begin
    w   = (img_w_q == '0) ? ImgW'(1) : ((img_w_q > MaxImage) ? MaxImage : img_w_q);
    h   = (img_h_q == '0) ? ImgW'(1) : ((img_h_q > MaxImage) ? MaxImage : img_h_q);
    tw  = (32'(tile_w_q) > MAX_TILE_DIM) ? TileW'(MAX_TILE_DIM) : tile_w_q;
    th  = (32'(tile_h_q) > MAX_TILE_DIM) ? TileW'(MAX_TILE_DIM) : tile_h_q;
    sr0 = (sample_q == '0) ? TileW'(1) : sample_q;
    sr  = (sr0 > th) ? th : sr0;
    sx  = StrideW'(tw) + StrideW'(spacing_q);
    sy  = StrideW'(th) + StrideW'(spacing_q);
    m2  = {4'b0, margin_q, 1'b0};
    geo_ok = (tw != '0) && (th != '0);
  end

  // raster position and tile coordinates
  state_e             state_q;
  logic               rc_pend_q;
  logic [1:0]         rc_idx_q;
  logic [PosW-1:0]    x_q, y_q, cx_q, ry_q;
  logic [StrideW-1:0] ox_q, dy_q;
  logic               mx_q, my_q;
  logic [ColsW-1:0]   cols_q;
  logic [ImgW-1:0]    rows_q;
  logic [KW-1:0]      k_q;
  logic               emit_q;
  logic [IdW-1:0]     base_q;

  logic in_band, in_col, line_end, band_end, frame_end, acc_ok, take, do_acc;

  assign acc_ok   = (state_q == S_RUN) && !rc_pend_q;
  assign take     = acc_ok && pix_i.valid;
  assign in_band  = geo_ok && my_q && (ImgW'(ry_q) < rows_q) && (dy_q < StrideW'(sr));
  assign in_col   = geo_ok && mx_q && (32'(cx_q) < 32'(cols_q)) && (ox_q < StrideW'(tw));
  assign line_end = (ImgW'(x_q) == w - 1'b1);
  assign band_end = line_end && in_band &&
                    ((dy_q == StrideW'(sr) - 1'b1) || (ImgW'(y_q) == h - 1'b1));
  assign frame_end = line_end && (ImgW'(y_q) >= h - 1'b1);
  assign do_acc   = in_band && in_col && (pix_i.alpha >= AlphaMin);
  assign pix_i.ready = acc_ok;

  // column memory
  col_acc_t          mem_q [MAX_COLS];
  col_acc_t          rd_q;
  logic [AW-1:0]     rd_addr;
  logic              s2_v_q;
  logic [AW-1:0]     s2_a_q;
  logic [7:0]        s2_r_q, s2_g_q, s2_b_q;
  logic              wr_v_q;
  logic [AW-1:0]     wr_a_q;
  col_acc_t          wr_d_q;
  col_acc_t          acc_base, acc_new;
  logic              mem_we;
  logic [AW-1:0]     mem_wa;
  col_acc_t          mem_wd;

  assign rd_addr = (state_q == S_RUN) ? cx_q[AW-1:0] : k_q[AW-1:0];

  always_comb begin
    // forward the word written last cycle when the same column comes again
    acc_base = (wr_v_q && wr_a_q == s2_a_q) ? wr_d_q : rd_q;
    acc_new.sum_r = acc_base.sum_r + SumW'(s2_r_q);
    acc_new.sum_g = acc_base.sum_g + SumW'(s2_g_q);
    acc_new.sum_b = acc_base.sum_b + SumW'(s2_b_q);
    acc_new.cnt   = acc_base.cnt + 1'b1;
    if (s2_v_q) begin
      mem_we = 1'b1;
      mem_wa = s2_a_q;
      mem_wd = acc_new;
    end else begin
      mem_we = (state_q == S_CHK);
      mem_wa = k_q[AW-1:0];
      mem_wd = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
    if (mem_we) begin
      mem_q[mem_wa] <= mem_wd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
      wr_v_q <= 1'b0;
      s2_a_q <= '0;
      s2_r_q <= '0;
      s2_g_q <= '0;
      s2_b_q <= '0;
      wr_a_q <= '0;
      wr_d_q <= '0;
    end else begin
      s2_v_q <= take && do_acc;
      s2_a_q <= cx_q[AW-1:0];
      s2_r_q <= pix_i.red;
      s2_g_q <= pix_i.green;
      s2_b_q <= pix_i.blue;
      wr_v_q <= mem_we;
      wr_a_q <= mem_wa;
      wr_d_q <= mem_wd;
    end
  end

  // dividers: unit 0 is shared with the geometry pass
  logic              rc_mode, div_start;
  logic [DivNW-1:0]  num0;
  logic [CntW-1:0]   den0;
  logic [DivNW-1:0]  q0, q1, q2;
  logic [CntW-1:0]   rem0, rem1, rem2;
  logic              done0, done1, done2;
  logic [ImgW-1:0]   rc_num;
  logic [StrideW-1:0] rc_den;
  logic              rc_skip;

  always_comb begin
    unique case (rc_idx_q)
      2'd0: begin rc_num = w - m2;                  rc_den = sx; rc_skip = !(w > m2); end
      2'd1: begin rc_num = h - m2;                  rc_den = sy; rc_skip = !(h > m2); end
      2'd2: begin rc_num = ImgW'(x_q) - ImgW'(margin_q); rc_den = sx;
                  rc_skip = (ImgW'(x_q) < ImgW'(margin_q)); end
      default: begin rc_num = ImgW'(y_q) - ImgW'(margin_q); rc_den = sy;
                  rc_skip = (ImgW'(y_q) < ImgW'(margin_q)); end
    endcase
  end

  logic chk_hit;
  assign chk_hit   = emit_q && (32'(k_q) < 32'(cols_q)) && (rd_q.cnt != '0);
  assign rc_mode   = (state_q == S_RCSTART);
  assign div_start = (rc_mode && !rc_skip) || ((state_q == S_CHK) && chk_hit);
  assign num0      = rc_mode ? DivNW'(rc_num) : {rd_q.sum_r, 8'b0};
  assign den0      = rc_mode ? CntW'(rc_den) : rd_q.cnt;

  tba_div u_div0 (.clk_i, .rst_ni, .start_i(div_start), .num_i(num0), .den_i(den0),
                  .done_o(done0), .quot_o(q0), .rem_o(rem0));
  tba_div u_div1 (.clk_i, .rst_ni, .start_i(div_start), .num_i({rd_q.sum_g, 8'b0}),
                  .den_i(rd_q.cnt), .done_o(done1), .quot_o(q1), .rem_o(rem1));
  tba_div u_div2 (.clk_i, .rst_ni, .start_i(div_start), .num_i({rd_q.sum_b, 8'b0}),
                  .den_i(rd_q.cnt), .done_o(done2), .quot_o(q2), .rem_o(rem2));

  // result hold and output register
  logic            hold_v_q;
  logic [IdW-1:0]  hold_id_q;
  logic [AvgW-1:0] hold_r_q, hold_g_q, hold_b_q;
  logic            out_v_q, out_last_q;
  logic [IdW-1:0]  out_id_q;
  logic [AvgW-1:0] out_r_q, out_g_q, out_b_q;
  logic            out_free, sweep_last;
  logic            out_load, rc_start;
  logic [CntW-1:0] rem_unused;

  assign out_free   = !out_v_q || res_o.ready;
  assign sweep_last = (k_q == KW'(MAX_COLS - 1));
  assign rem_unused = rem1 ^ rem2;
  // the held item moves to the output register this cycle
  assign out_load   = ((state_q == S_PUSH) || (state_q == S_FLUSH)) && hold_v_q && out_free;
  assign rc_start   = (state_q == S_RUN) && rc_pend_q && !s2_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_RD;
      rc_pend_q  <= 1'b1;
      rc_idx_q   <= '0;
      x_q        <= '0;
      y_q        <= '0;
      cx_q       <= '0;
      ry_q       <= '0;
      ox_q       <= '0;
      dy_q       <= '0;
      mx_q       <= 1'b0;
      my_q       <= 1'b0;
      cols_q     <= ColsW'(1);
      rows_q     <= ImgW'(1);
      k_q        <= '0;
      emit_q     <= 1'b0;
      base_q     <= '0;
      hold_v_q   <= 1'b0;
      hold_id_q  <= '0;
      hold_r_q   <= '0;
      hold_g_q   <= '0;
      hold_b_q   <= '0;
      out_v_q    <= 1'b0;
      out_last_q <= 1'b0;
      out_id_q   <= '0;
      out_r_q    <= '0;
      out_g_q    <= '0;
      out_b_q    <= '0;
    end else begin
      if (out_v_q && res_o.ready && !out_load) begin
        out_v_q <= 1'b0;
      end
      if (cfg_we_i) begin
        rc_pend_q <= 1'b1;
      end else if (rc_start) begin
        rc_pend_q <= 1'b0;
      end
      unique case (state_q)
        S_RUN: begin
          if (take) begin
            if (line_end) begin
              x_q  <= '0;
              mx_q <= (margin_q == '0);
              cx_q <= '0;
              ox_q <= '0;
              if (frame_end) begin
                y_q  <= '0;
                my_q <= (margin_q == '0);
                ry_q <= '0;
                dy_q <= '0;
              end else begin
                y_q <= y_q + 1'b1;
                if (!my_q) begin
                  if (y_q + 1'b1 == PosW'(margin_q)) begin
                    my_q <= 1'b1;
                    ry_q <= '0;
                    dy_q <= '0;
                  end
                end else if (dy_q + 1'b1 == sy) begin
                  ry_q <= ry_q + 1'b1;
                  dy_q <= '0;
                end else begin
                  dy_q <= dy_q + 1'b1;
                end
              end
            end else begin
              x_q <= x_q + 1'b1;
              if (!mx_q) begin
                if (x_q + 1'b1 == PosW'(margin_q)) begin
                  mx_q <= 1'b1;
                  cx_q <= '0;
                  ox_q <= '0;
                end
              end else if (ox_q + 1'b1 == sx) begin
                cx_q <= cx_q + 1'b1;
                ox_q <= '0;
              end else begin
                ox_q <= ox_q + 1'b1;
              end
            end
            if (band_end || frame_end) begin
              emit_q  <= band_end;
              base_q  <= IdW'(ry_q) * IdW'(cols_q);
              k_q     <= '0;
              state_q <= S_WAIT;
            end
          end else if (rc_start) begin
            state_q <= S_RCPOS;
          end
        end
        S_WAIT: state_q <= S_RD;
        S_RD:   state_q <= S_CHK;
        S_CHK: begin
          if (chk_hit) begin
            state_q <= S_DIV;
          end else if (sweep_last) begin
            state_q <= emit_q ? S_FLUSH : S_RUN;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_DIV: begin
          if (done0 && done1 && done2) begin
            state_q <= S_PUSH;
          end
        end
        S_PUSH: begin
          if (!hold_v_q || out_free) begin
            if (hold_v_q) begin
              out_v_q    <= 1'b1;
              out_last_q <= 1'b0;
              out_id_q   <= hold_id_q;
              out_r_q    <= hold_r_q;
              out_g_q    <= hold_g_q;
              out_b_q    <= hold_b_q;
            end
            hold_v_q  <= 1'b1;
            hold_id_q <= base_q + IdW'(k_q) + 1'b1;
            hold_r_q  <= q0[AvgW-1:0];
            hold_g_q  <= q1[AvgW-1:0];
            hold_b_q  <= q2[AvgW-1:0];
            if (sweep_last) begin
              state_q <= S_FLUSH;
            end else begin
              k_q     <= k_q + 1'b1;
              state_q <= S_RD;
            end
          end
        end
        S_FLUSH: begin
          if (!hold_v_q) begin
            state_q <= S_RUN;
          end else if (out_free) begin
            out_v_q    <= 1'b1;
            out_last_q <= 1'b1;
            out_id_q   <= hold_id_q;
            out_r_q    <= hold_r_q;
            out_g_q    <= hold_g_q;
            out_b_q    <= hold_b_q;
            hold_v_q   <= 1'b0;
            state_q    <= S_RUN;
          end
        end
        S_RCPOS: begin
          if (ImgW'(x_q) >= w) x_q <= '0;
          if (ImgW'(y_q) >= h) y_q <= '0;
          rc_idx_q <= '0;
          if (geo_ok) begin
            state_q <= S_RCSTART;
          end else begin
            cols_q  <= ColsW'(1);
            rows_q  <= ImgW'(1);
            mx_q    <= 1'b0;
            my_q    <= 1'b0;
            state_q <= S_RUN;
          end
        end
        S_RCSTART: begin
          if (rc_skip) begin
            unique case (rc_idx_q)
              2'd0: cols_q <= ColsW'(1);
              2'd1: rows_q <= ImgW'(1);
              2'd2: begin mx_q <= 1'b0; cx_q <= '0; ox_q <= '0; end
              default: begin my_q <= 1'b0; ry_q <= '0; dy_q <= '0; end
            endcase
            rc_idx_q <= rc_idx_q + 1'b1;
            if (rc_idx_q == 2'd3) state_q <= S_RUN;
          end else begin
            state_q <= S_RCWAIT;
          end
        end
        S_RCWAIT: begin
          if (done0) begin
            unique case (rc_idx_q)
              2'd0: cols_q <= (q0 == '0) ? ColsW'(1) :
                              ((q0 > DivNW'(MAX_COLS)) ? ColsW'(MAX_COLS) : ColsW'(q0));
              2'd1: rows_q <= (q0 == '0) ? ImgW'(1) : ImgW'(q0);
              2'd2: begin mx_q <= 1'b1; cx_q <= PosW'(q0); ox_q <= StrideW'(rem0); end
              default: begin my_q <= 1'b1; ry_q <= PosW'(q0); dy_q <= StrideW'(rem0); end
            endcase
            rc_idx_q <= rc_idx_q + 1'b1;
            state_q  <= (rc_idx_q == 2'd3) ? S_RUN : S_RCSTART;
          end
        end
        default: state_q <= S_RUN;
      endcase
    end
  end

  assign res_o.valid       = out_v_q;
  assign res_o.tile_id     = out_id_q;
  assign res_o.avg_red     = out_r_q;
  assign res_o.avg_green   = out_g_q;
  assign res_o.avg_blue    = out_b_q;
  assign res_o.last_of_run = out_last_q & ~(&rem_unused & 1'b0);

endmodule

@@ sv/tba_div.sv @@
// restoring divider, one quotient bit per cycle
module tba_div import tba_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [DivNW-1:0] num_i,
  input  logic [CntW-1:0]  den_i,
  output logic             done_o,
  output logic [DivNW-1:0] quot_o,
  output logic [CntW-1:0]  rem_o
);

  localparam int unsigned StepW = $clog2(DivNW + 1);

  logic [DivNW-1:0] quot_q;
  logic [CntW-1:0]  rem_q;
  logic [CntW-1:0]  den_q;
  logic [StepW-1:0] step_q;
  logic             busy_q;
  logic             done_q;
  logic [CntW:0]    trial;
  logic             fits;

  assign trial = {rem_q, quot_q[DivNW-1]};
  assign fits  = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quot_q <= '0;
      rem_q  <= '0;
      den_q  <= '0;
      step_q <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        quot_q <= num_i;
        rem_q  <= '0;
        den_q  <= den_i;
        step_q <= StepW'(DivNW);
        busy_q <= 1'b1;
      end else if (busy_q) begin
        rem_q  <= fits ? CntW'(trial - {1'b0, den_q}) : trial[CntW-1:0];
        quot_q <= {quot_q[DivNW-2:0], fits};
        step_q <= step_q - 1'b1;
        if (step_q == StepW'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;
  assign rem_o  = rem_q;

endmodule

@@ verif/testbench.sv @@
// self-checking testbench of the tile band colour averager
module testbench;
  import tba_pkg::*;

  typedef struct {
    logic [IdW-1:0]  tile_id;
    logic [AvgW-1:0] avg_red;
    logic [AvgW-1:0] avg_green;
    logic [AvgW-1:0] avg_blue;
    logic            last_of_run;
  } tile_avg_t;

  localparam int unsigned NumCols = 64;
  localparam int unsigned SettleCycles = 400;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxW-1:0] cfg_idx_i;
  logic [CfgW-1:0] cfg_data_i;

  tba_pix_if pix ();
  tba_res_if res ();

  tile_top_band_color_average uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pix_i      (pix),
    .res_o      (res)
  );

  // predictor state
  int unsigned band_reg [0:6];
  int unsigned pos_x, pos_y, band_row;
  int unsigned col_red [NumCols];
  int unsigned col_green [NumCols];
  int unsigned col_blue [NumCols];
  int unsigned col_cnt [NumCols];
  tile_avg_t tile_avgs_due [$];

  bit failed;
  bit calm;
  int unsigned stall_left;

  always #5 clk_i = ~clk_i;

  function automatic void clear_columns();
    foreach (col_cnt[k]) begin
      col_red[k] = 0;
      col_green[k] = 0;
      col_blue[k] = 0;
      col_cnt[k] = 0;
    end
  endfunction

  function automatic int unsigned tiles_along(int unsigned extent, int unsigned margin,
                                              int unsigned stride);
    int unsigned n;
    n = 0;
    if (extent > 2 * margin) n = (extent - 2 * margin) / stride;
    return (n < 1) ? 1 : n;
  endfunction

  function automatic void predict_pixel(logic [7:0] red, logic [7:0] green,
                                        logic [7:0] blue, logic [7:0] alpha);
    int unsigned w, h, tw, th, sr, m, sx, sy, cols, rows, x, y, row, dy, col, n;
    bit usable, in_band, in_col;
    tile_avg_t t;
    w  = band_reg[CFG_IMG_W] == 0 ? 1 : (band_reg[CFG_IMG_W] > 4096 ? 4096 : band_reg[CFG_IMG_W]);
    h  = band_reg[CFG_IMG_H] == 0 ? 1 : (band_reg[CFG_IMG_H] > 4096 ? 4096 : band_reg[CFG_IMG_H]);
    tw = band_reg[CFG_TILE_W] > 256 ? 256 : band_reg[CFG_TILE_W];
    th = band_reg[CFG_TILE_H] > 256 ? 256 : band_reg[CFG_TILE_H];
    sr = band_reg[CFG_SAMPLE] == 0 ? 1 : band_reg[CFG_SAMPLE];
    m  = band_reg[CFG_MARGIN];
    usable = tw != 0 && th != 0;
    sx = tw + band_reg[CFG_SPACING];
    sy = th + band_reg[CFG_SPACING];
    cols = 1; rows = 1; row = 0; dy = 0; col = 0; n = 0;
    in_band = 0; in_col = 0;
    if (sr > th) sr = th;
    if (pos_x >= w) pos_x = 0;
    if (pos_y >= h) pos_y = 0;
    x = pos_x;
    y = pos_y;
    if (usable) begin
      cols = tiles_along(w, m, sx);
      if (cols > NumCols) cols = NumCols;
      rows = tiles_along(h, m, sy);
      if (y >= m) begin
        row = (y - m) / sy;
        dy = (y - m) % sy;
        in_band = row < rows && dy < sr;
      end
      if (x >= m) begin
        col = (x - m) / sx;
        in_col = col < cols && (x - m) % sx < tw;
      end
    end
    if (in_band) begin
      band_row = row & 12'hFFF;
      if (in_col && alpha >= AlphaMin) begin
        col_red[col]   = (col_red[col] + red) & 24'hFFFFFF;
        col_green[col] = (col_green[col] + green) & 24'hFFFFFF;
        col_blue[col]  = (col_blue[col] + blue) & 24'hFFFFFF;
        col_cnt[col]   = (col_cnt[col] + 1) & 17'h1FFFF;
      end
    end
    if (x == w - 1) begin
      if (in_band && (dy == sr - 1 || y == h - 1)) begin
        for (int unsigned k = 0; k < cols; k++) begin
          if (col_cnt[k] != 0) begin
            t.tile_id     = IdW'(band_row * cols + k + 1);
            t.avg_red     = AvgW'((longint'(col_red[k]) << 8) / col_cnt[k]);
            t.avg_green   = AvgW'((longint'(col_green[k]) << 8) / col_cnt[k]);
            t.avg_blue    = AvgW'((longint'(col_blue[k]) << 8) / col_cnt[k]);
            t.last_of_run = 1'b0;
            tile_avgs_due = {tile_avgs_due, t};
            n++;
          end
        end
        if (n > 0) tile_avgs_due[$].last_of_run = 1'b1;
        clear_columns();
      end
      pos_x = 0;
      if (y >= h - 1) begin
        pos_y = 0;
        band_row = 0;
        clear_columns();
      end else begin
        pos_y = y + 1;
      end
    end else begin
      pos_x = x + 1;
    end
  endfunction

  task automatic send_pixel(logic [7:0] red, logic [7:0] green, logic [7:0] blue,
                            logic [7:0] alpha);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      pix.valid = 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    pix.valid = 1'b1;
    pix.red   = red;
    pix.green = green;
    pix.blue  = blue;
    pix.alpha = alpha;
    do @(posedge clk_i); while (!pix.ready);
    predict_pixel(red, green, blue, alpha);
  endtask

  task automatic send_random_pixels(int unsigned count);
    logic [7:0] alpha;
    repeat (count) begin
      // mostly random alpha, a few below AlphaMin that are skipped
      alpha = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 7)) : 8'($urandom);
      send_pixel(8'($urandom), 8'($urandom), 8'($urandom), alpha);
    end
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    pix.valid = 1'b0;
    while (tile_avgs_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, int unsigned value);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = CfgW'(value);
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    case (idx) inside
      CFG_TILE_W, CFG_TILE_H, CFG_SAMPLE: band_reg[idx] = value & 9'h1FF;
      CFG_SPACING, CFG_MARGIN:            band_reg[idx] = value & 8'hFF;
      default:                            band_reg[idx] = value & 13'h1FFF;
    endcase
  endtask

  task automatic set_layout(int unsigned iw, int unsigned ih, int unsigned tw,
                            int unsigned th, int unsigned sp, int unsigned mg,
                            int unsigned sr);
    wait_idle();
    write_reg(CFG_IMG_W, iw);
    write_reg(CFG_IMG_H, ih);
    write_reg(CFG_TILE_W, tw);
    write_reg(CFG_TILE_H, th);
    write_reg(CFG_SPACING, sp);
    write_reg(CFG_MARGIN, mg);
    write_reg(CFG_SAMPLE, sr);
  endtask

  // field extremes, skipped alpha and the frame wrap on a 6x3 atlas of 2x2 tiles
  task automatic test_directed();
    set_layout(6, 3, 2, 2, 0, 0, 2);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd8);
    send_pixel(8'd255, 8'd0, 8'd128, 8'd7);
    send_pixel(8'd1, 8'd2, 8'd3, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd15, 8'd128);
    send_pixel(8'd85, 8'd170, 8'd240, 8'd9);
    send_pixel(8'd7, 8'd7, 8'd7, 8'd7);
    send_pixel(8'd0, 8'd255, 8'd0, 8'd200);
    send_pixel(8'd0, 8'd0, 8'd0, 8'd0);
    send_pixel(8'd128, 8'd64, 8'd32, 8'd64);
    send_pixel(8'd255, 8'd0, 8'd255, 8'd16);
    send_random_pixels(8);
  endtask

  task automatic test_odd_settings();
    // zero tile width: nothing gathered
    set_layout(5, 2, 0, 2, 0, 0, 1);
    send_random_pixels(12);
    // zero sample rows and zero image sizes
    set_layout(0, 0, 1, 1, 0, 0, 0);
    send_random_pixels(3);
    // oversized tiles, oversized image height, margins and gaps at their top
    set_layout(20, 8191, 511, 511, 255, 255, 511);
    send_random_pixels(10);
    set_layout(9, 3, 2, 1, 255, 1, 3);
    send_random_pixels(27);
    // tiles of 256 with a band cut by the image bottom
    set_layout(20, 1, 256, 256, 0, 0, 256);
    send_random_pixels(20);
    // tall image, every pixel ends a band
    set_layout(1, 4096, 1, 1, 0, 0, 1);
    send_random_pixels(20);
  endtask

  // more columns than the block keeps
  task automatic test_wide_atlas();
    set_layout(100, 1, 1, 1, 0, 0, 1);
    send_random_pixels(100);
    set_layout(140, 1, 1, 2, 1, 3, 2);
    send_random_pixels(140);
  endtask

  task automatic test_random();
    for (int phase = 0; phase < 10; phase++) begin
      if (phase == 7) calm = 1'b1;
      set_layout($urandom_range(1, 24), $urandom_range(1, 8), $urandom_range(1, 6),
                 $urandom_range(1, 4), $urandom_range(0, 2), $urandom_range(0, 2),
                 $urandom_range(0, 5));
      send_random_pixels($urandom_range(6, 14));
    end
  endtask

  // result side: random stalls
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      res.ready = 1'b0;
    end else if (!calm && $urandom_range(0, 6) == 0) begin
      stall_left = $urandom_range(0, 3);
      res.ready = 1'b0;
    end else begin
      res.ready = 1'b1;
    end
  end

  always @(posedge clk_i) begin
    tile_avg_t t;
    if (rst_ni && res.valid && res.ready) begin
      if (tile_avgs_due.size() == 0) begin
        $error("tile result with none due: tile_id %0d", res.tile_id);
        failed = 1'b1;
      end else begin
        t = tile_avgs_due.pop_front();
        if (res.tile_id !== t.tile_id) begin
          $error("tile_id expected %0d got %0d", t.tile_id, res.tile_id);
          failed = 1'b1;
        end
        if (res.avg_red !== t.avg_red) begin
          $error("avg_red expected %0h got %0h", t.avg_red, res.avg_red);
          failed = 1'b1;
        end
        if (res.avg_green !== t.avg_green) begin
          $error("avg_green expected %0h got %0h", t.avg_green, res.avg_green);
          failed = 1'b1;
        end
        if (res.avg_blue !== t.avg_blue) begin
          $error("avg_blue expected %0h got %0h", t.avg_blue, res.avg_blue);
          failed = 1'b1;
        end
        if (res.last_of_run !== t.last_of_run) begin
          $error("last_of_run expected %0b got %0b", t.last_of_run, res.last_of_run);
          failed = 1'b1;
        end
      end
    end
  end

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NONE;
    cfg_data_i = '0;
    pix.valid = 1'b0;
    pix.red = '0;
    pix.green = '0;
    pix.blue = '0;
    pix.alpha = '0;
    res.ready = 1'b0;
    stall_left = 0;
    calm = 1'b0;
    failed = 1'b0;
    band_reg = '{16, 16, 0, 0, 1, 256, 256};
    pos_x = 0; pos_y = 0; band_row = 0;
    clear_columns();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_odd_settings();
    test_wide_atlas();
    test_random();
    wait_idle();
    if (!failed) begin
      $display("tile_top_band_color_average test passed");
    end else begin
      $display("tile_top_band_color_average test failed");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("tile_top_band_color_average test failed");
    $finish;
  end

endmodule
